>>> rtl/core/mhed_pkg.sv
// Shared types and constants for the hysteresis event detector.
`timescale 1ns / 1ps

package mhed_pkg;

	localparam int SAMPLE_W = 12;
	localparam int VAL_W = 14;
	localparam int ANALOGUE_SHIFT = 4;
	localparam logic [7:0] SWITCH_HYST = 8'd6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	localparam logic [1:0] KIND_ANALOGUE = 2'd0;
	localparam logic [1:0] KIND_MAGNET = 2'd1;
	localparam logic [1:0] KIND_SWITCH = 2'd2;
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic [3:0] channel;
		logic [SAMPLE_W-1:0] sample;
		logic [1:0] kind;
		logic [SAMPLE_W-1:0] offset;
		logic [7:0] threshold;
		logic [7:0] hysteresis;
		logic result_inverted;
		logic disable_off;
		logic toggle_mode;
		logic trigger_inverted;
	} item_t;

	typedef struct packed {
		logic [3:0] event_channel;
		logic upper_event;
		logic level_on;
		logic last;
	} result_t;

	typedef struct packed {
		logic [3:0] channel;
		logic upper_valid;
		logic upper_level;
		logic lower_valid;
		logic lower_level;
	} group_t;

endpackage

>>> rtl/core/mhed_front.sv
// Front end: per-channel zone state, edge compares and event classification.
`timescale 1ns / 1ps

module mhed_front #(
	parameter int CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  mhed_pkg::item_t   item,
	output logic              grp_push,
	output mhed_pkg::group_t  grp
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [1:0] {
		ZONE_OFF   = 2'd0,
		ZONE_LOWER = 2'd1,
		ZONE_UPPER = 2'd2
	} zone_t;

	logic [CHANNELS-1:0] armed_q;
	zone_t zone_q [CHANNELS];
	logic toggle_q [CHANNELS];

	logic [31:0] ch_ext;
	logic [IDX_W-1:0] idx;
	logic in_range;
	logic active;
	logic ready;
	zone_t zone_r;
	logic tog_r;
	logic is_magnet;
	mhed_pkg::val_t v_mag;
	mhed_pkg::val_t v_ana;
	mhed_pkg::val_t v;
	mhed_pkg::val_t high_on;
	mhed_pkg::val_t high_off;
	mhed_pkg::val_t low_on;
	mhed_pkg::val_t low_off;
	logic [7:0] lo_hyst;
	logic up_on;
	logic up_off;
	zone_t zone_mid;
	logic lo_on;
	logic lo_off;
	zone_t zone_new;
	logic flip;
	logic tog_new;

	always_comb begin
		ch_ext = 32'(item.channel);
		idx = ch_ext[IDX_W-1:0];
		in_range = ch_ext < 32'(CHANNELS);
		active = accept && in_range && (item.kind != mhed_pkg::KIND_IGNORED);
		ready = armed_q[idx];
		zone_r = ready ? zone_q[idx] : ZONE_OFF;
		tog_r = ready ? toggle_q[idx] : 1'b0;
		is_magnet = item.kind == mhed_pkg::KIND_MAGNET;

		v_mag = mhed_pkg::val_t'(item.sample);
		v_ana = mhed_pkg::val_t'(item.sample >> mhed_pkg::ANALOGUE_SHIFT);
		high_on = mhed_pkg::val_t'(item.offset) + mhed_pkg::val_t'(item.threshold);
		high_off = high_on - mhed_pkg::val_t'(item.hysteresis);
		lo_hyst = (item.kind == mhed_pkg::KIND_ANALOGUE) ? item.hysteresis
			: mhed_pkg::SWITCH_HYST;

		if (is_magnet) begin
			v = v_mag;
			low_on = mhed_pkg::val_t'(item.offset) - mhed_pkg::val_t'(item.threshold);
			low_off = low_on + mhed_pkg::val_t'(item.hysteresis);
		end else begin
			v = v_ana;
			low_on = mhed_pkg::val_t'(item.threshold);
			low_off = low_on + mhed_pkg::val_t'(lo_hyst);
		end

		up_on = is_magnet && (zone_r != ZONE_UPPER) && (v >= high_on);
		up_off = is_magnet && !up_on && (zone_r == ZONE_UPPER) && (v <= high_off);
		zone_mid = up_on ? ZONE_UPPER : (up_off ? ZONE_OFF : zone_r);

		lo_on = (zone_mid != ZONE_LOWER) && (v <= low_on);
		lo_off = !lo_on && (zone_mid == ZONE_LOWER) && (v >= low_off);
		zone_new = lo_on ? ZONE_LOWER : (lo_off ? ZONE_OFF : zone_mid);

		flip = ready && item.toggle_mode
			&& ((lo_on && !item.trigger_inverted) || (lo_off && item.trigger_inverted));
		tog_new = tog_r ^ flip;

		grp.channel = item.channel;
		grp.upper_valid = ready && (up_on || (up_off && !item.disable_off));
		grp.upper_level = up_on ? !item.result_inverted : item.result_inverted;
		grp.lower_valid = item.toggle_mode ? flip
			: (ready && (lo_on || (lo_off && !item.disable_off)));
		grp.lower_level = item.toggle_mode ? tog_new
			: (lo_on ? !item.result_inverted : item.result_inverted);
		grp_push = active && (grp.upper_valid || grp.lower_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (active) begin
			armed_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			zone_q[idx] <= zone_new;
			toggle_q[idx] <= tog_new;
		end
	end

endmodule

>>> rtl/core/mhed_fifo.sv
// Short queue of event groups between the front end and the output stage.
`timescale 1ns / 1ps

module mhed_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  mhed_pkg::group_t  wdata,
	input  logic              rd,
	output mhed_pkg::group_t  rdata,
	output logic              q_full,
	output logic              q_empty
);

	mhed_pkg::group_t mem_q [mhed_pkg::QUEUE_DEPTH];
	logic [mhed_pkg::QUEUE_AW-1:0] wptr_q;
	logic [mhed_pkg::QUEUE_AW-1:0] rptr_q;
	logic [mhed_pkg::QUEUE_AW:0] count_q;

	assign q_full = count_q == (mhed_pkg::QUEUE_AW + 1)'(mhed_pkg::QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !wr)
		else $error("Queue written while full.");
	assert property (@(posedge clk) disable iff (!arst_n) q_empty |-> !rd)
		else $error("Queue read while empty.");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (mhed_pkg::QUEUE_AW + 1)'(mhed_pkg::QUEUE_DEPTH))
		else $error("Queue count beyond its depth.");

endmodule

>>> rtl/core/mhed_back.sv
// Output stage: splits event groups into single result words.
`timescale 1ns / 1ps

module mhed_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  mhed_pkg::group_t   q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output mhed_pkg::result_t  result
);

	logic out_valid_q;
	logic pend_valid_q;
	mhed_pkg::result_t out_q;
	mhed_pkg::result_t pend_q;
	logic advance;
	mhed_pkg::result_t up_word;
	mhed_pkg::result_t lo_word;

	always_comb begin
		advance = !out_valid_q || pop;
		q_pop = advance && !pend_valid_q && !q_empty;
		up_word.event_channel = q_data.channel;
		up_word.upper_event = 1'b1;
		up_word.level_on = q_data.upper_level;
		up_word.last = !q_data.lower_valid;
		lo_word.event_channel = q_data.channel;
		lo_word.upper_event = 1'b0;
		lo_word.level_on = q_data.lower_level;
		lo_word.last = 1'b1;
	end

	assign empty = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (advance) begin
			if (pend_valid_q) begin
				out_valid_q <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				pend_valid_q <= q_data.upper_valid && q_data.lower_valid;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (!q_empty) begin
				out_q <= q_data.upper_valid ? up_word : lo_word;
				pend_q <= lo_word;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pend_valid_q |-> out_valid_q)
		else $error("Pending word without a word on the output.");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> pend_valid_q)
		else $error("Word not marked last has no follower.");
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (out_q.upper_event && !pend_q.upper_event
			&& pend_q.last && (out_q.event_channel == pend_q.event_channel)))
		else $error("Pending word does not pair with the upper word.");

endmodule

>>> rtl/core/multichannel_hysteresis_event_detector_unit.sv
// Top level of the multichannel hysteresis event detector.
`timescale 1ns / 1ps

// Accepts one sample word per clock cycle whenever full is low; state for the
// sample's channel is read and updated in the cycle the word is accepted, so
// samples for the same channel may follow each other in consecutive cycles.
// Each sample gives zero, one or two result words. The output register sends
// one result word per cycle while pop is high; a sample that gives two words
// occupies it for both, and a four-entry queue of event groups in front of it
// absorbs bursts. The first result word is written into the queue and then
// into the output register. Full is raised only when that queue is full.

module multichannel_hysteresis_event_detector_unit #(
	parameter int CHANNELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mhed_pkg::item_t    item,
	output logic               empty,
	input  logic               pop,
	output mhed_pkg::result_t  result
);

	logic accept;
	logic grp_push;
	mhed_pkg::group_t grp;
	mhed_pkg::group_t q_data;
	logic q_pop;
	logic q_empty;

	assign accept = push && !full;

	mhed_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.grp_push (grp_push),
		.grp      (grp)
	);

	mhed_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (grp_push),
		.wdata   (grp),
		.rd      (q_pop),
		.rdata   (q_data),
		.q_full  (full),
		.q_empty (q_empty)
	);

	mhed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

>>> test/multichannel_hysteresis_event_detector_unit_tb.sv
// Self-checking testbench for the multichannel hysteresis event detector.
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_CHANNELS = 16;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {ZONE_OFF, ZONE_LOWER, ZONE_UPPER} zone_t;
	typedef enum {GAPS_NONE, GAPS_SHORT, GAPS_LONG} gap_mode_t;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	mhed_pkg::item_t item;
	logic empty;
	logic pop = 1'b0;
	mhed_pkg::result_t result;

	zone_t ch_zone[NUM_CHANNELS];
	bit ch_armed[NUM_CHANNELS];
	bit ch_toggle[NUM_CHANNELS];
	mhed_pkg::item_t chan_settings[NUM_CHANNELS];

	mhed_pkg::result_t pending_events[$];
	int mismatch_count = 0;
	int burst_left = 0;
	gap_mode_t gap_mode = GAPS_SHORT;
	stall_mode_t stall_mode = STALL_LIGHT;
	bit pop_phase = 1'b0;
	int pop_left = 0;

	multichannel_hysteresis_event_detector_unit #(
		.CHANNELS(NUM_CHANNELS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void detect_events(input mhed_pkg::item_t it);
		mhed_pkg::result_t found[$];
		int c;
		int v;
		int low_on;
		int low_off;
		int high_on;
		int high_off;
		bit ready;
		if (it.kind == mhed_pkg::KIND_IGNORED || int'(it.channel) >= NUM_CHANNELS)
			return;
		c = int'(it.channel);
		ready = ch_armed[c];
		if (it.kind == mhed_pkg::KIND_MAGNET) begin
			high_on = int'(it.offset) + int'(it.threshold);
			high_off = high_on - int'(it.hysteresis);
			low_on = int'(it.offset) - int'(it.threshold);
			low_off = low_on + int'(it.hysteresis);
			v = int'(it.sample);
			if (ch_zone[c] != ZONE_UPPER && v >= high_on) begin
				if (ready)
					found.push_back(mhed_pkg::result_t'{it.channel, 1'b1,
						!it.result_inverted, 1'b0});
				ch_zone[c] = ZONE_UPPER;
			end else if (ch_zone[c] == ZONE_UPPER && v <= high_off) begin
				if (ready && !it.disable_off)
					found.push_back(mhed_pkg::result_t'{it.channel, 1'b1,
						it.result_inverted, 1'b0});
				ch_zone[c] = ZONE_OFF;
			end
		end else begin
			v = int'(it.sample) >> mhed_pkg::ANALOGUE_SHIFT;
			low_on = int'(it.threshold);
			low_off = low_on + (it.kind == mhed_pkg::KIND_ANALOGUE ? int'(it.hysteresis) :
				int'(mhed_pkg::SWITCH_HYST));
		end
		if (ch_zone[c] != ZONE_LOWER && v <= low_on) begin
			if (ready) begin
				if (it.toggle_mode) begin
					if (!it.trigger_inverted) begin
						ch_toggle[c] = !ch_toggle[c];
						found.push_back(mhed_pkg::result_t'{it.channel, 1'b0,
							ch_toggle[c], 1'b0});
					end
				end else begin
					found.push_back(mhed_pkg::result_t'{it.channel, 1'b0,
						!it.result_inverted, 1'b0});
				end
			end
			ch_zone[c] = ZONE_LOWER;
		end else if (ch_zone[c] == ZONE_LOWER && v >= low_off) begin
			if (ready) begin
				if (it.toggle_mode) begin
					if (it.trigger_inverted) begin
						ch_toggle[c] = !ch_toggle[c];
						found.push_back(mhed_pkg::result_t'{it.channel, 1'b0,
							ch_toggle[c], 1'b0});
					end
				end else if (!it.disable_off) begin
					found.push_back(mhed_pkg::result_t'{it.channel, 1'b0,
						it.result_inverted, 1'b0});
				end
			end
			ch_zone[c] = ZONE_OFF;
		end
		ch_armed[c] = 1'b1;
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			pending_events.push_back(found[i]);
	endfunction

	function automatic void report_mismatch(input string what,
			input mhed_pkg::result_t want, input mhed_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected ch %0d upper %b on %b last %b, %s %0d %s %b %s %b %s %b",
				$realtime, what, want.event_channel, want.upper_event, want.level_on,
				want.last, "got ch", got.event_channel, "upper", got.upper_event,
				"on", got.level_on, "last", got.last);
		end
	endfunction

	task automatic check_event(input mhed_pkg::result_t got);
		mhed_pkg::result_t want;
		if (pending_events.size() == 0) begin
			report_mismatch("result word with nothing pending", '0, got);
			return;
		end
		want = pending_events.pop_front();
		if (got.event_channel !== want.event_channel || got.upper_event !== want.upper_event ||
				got.level_on !== want.level_on || got.last !== want.last)
			report_mismatch("result word differs", want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n !== 1'b1) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_event(result);
			if (pop_left <= 0) begin
				pop_phase = !pop_phase;
				case (stall_mode)
				STALL_NONE: begin
					pop_phase = 1'b1;
					pop_left = 16;
				end
				STALL_LIGHT: begin
					pop_left = pop_phase ? $urandom_range(8, 1) : $urandom_range(3, 1);
				end
				default: begin
					pop_left = pop_phase ? $urandom_range(3, 1) : $urandom_range(20, 5);
				end
				endcase
			end
			pop_left--;
			pop <= pop_phase;
		end
	end

	task automatic send_sample(input mhed_pkg::item_t it);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(12, 1);
			case (gap_mode)
			GAPS_NONE: gap = 0;
			GAPS_SHORT: gap = $urandom_range(3, 0);
			default: gap = $urandom_range(15, 0);
			endcase
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		detect_events(it);
	endtask

	task automatic wait_all_events();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_events.size() != 0);
	endtask

	function automatic mhed_pkg::item_t make_sample(input int ch, input logic [1:0] kind,
			input int sample, input int offset, input int thr, input int hyst,
			input bit inv, input bit no_off, input bit tog, input bit trig_inv);
		mhed_pkg::item_t it;
		it.channel = ch[3:0];
		it.sample = sample[mhed_pkg::SAMPLE_W-1:0];
		it.kind = kind;
		it.offset = offset[mhed_pkg::SAMPLE_W-1:0];
		it.threshold = thr[7:0];
		it.hysteresis = hyst[7:0];
		it.result_inverted = inv;
		it.disable_off = no_off;
		it.toggle_mode = tog;
		it.trigger_inverted = trig_inv;
		return it;
	endfunction

	function automatic mhed_pkg::item_t random_settings(input int ch);
		mhed_pkg::item_t it;
		logic [63:0] raw;
		int roll;
		raw = {$urandom, $urandom};
		it = raw[$bits(mhed_pkg::item_t)-1:0];
		it.channel = ch[3:0];
		it.kind = 2'($urandom_range(2, 0));
		roll = $urandom_range(9, 0);
		it.offset = roll == 0 ? 12'd0 : roll == 1 ? 12'hfff : 12'($urandom);
		roll = $urandom_range(9, 0);
		it.threshold = roll == 0 ? 8'd0 : roll == 1 ? 8'hff : roll < 6 ?
			8'($urandom_range(40, 0)) : 8'($urandom);
		roll = $urandom_range(9, 0);
		it.hysteresis = roll == 0 ? 8'd0 : roll == 1 ? 8'hff : roll < 6 ?
			8'($urandom_range(20, 0)) : 8'($urandom);
		return it;
	endfunction

	function automatic logic [mhed_pkg::SAMPLE_W-1:0] pick_sample(input mhed_pkg::item_t it);
		int target;
		int s;
		int delta;
		delta = int'($urandom_range(6, 0)) - 3;
		if ($urandom_range(9, 0) == 0) begin
			s = $urandom_range(4095, 0);
		end else if (it.kind == mhed_pkg::KIND_MAGNET) begin
			case ($urandom_range(3, 0))
			0: target = int'(it.offset) + int'(it.threshold);
			1: target = int'(it.offset) + int'(it.threshold) - int'(it.hysteresis);
			2: target = int'(it.offset) - int'(it.threshold);
			default: target = int'(it.offset) - int'(it.threshold) + int'(it.hysteresis);
			endcase
			s = target + delta;
		end else begin
			target = int'(it.threshold);
			if ($urandom_range(1, 0) == 1)
				target += it.kind == mhed_pkg::KIND_ANALOGUE ? int'(it.hysteresis) :
					int'(mhed_pkg::SWITCH_HYST);
			s = (target + delta) * 16 + int'($urandom_range(15, 0));
		end
		if (s < 0)
			s = 0;
		if (s > 4095)
			s = 4095;
		return s[mhed_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic test_ignored_kind();
		send_sample(make_sample(1, mhed_pkg::KIND_IGNORED, 0, 0, 255, 0, 0, 0, 0, 0));
	endtask

	task automatic test_arming();
		send_sample(make_sample(1, mhed_pkg::KIND_ANALOGUE, 0, 0, 255, 0, 0, 0, 0, 0));
		send_sample(make_sample(1, mhed_pkg::KIND_ANALOGUE, 4095, 0, 255, 0, 0, 0, 0, 0));
		send_sample(make_sample(1, mhed_pkg::KIND_ANALOGUE, 0, 0, 255, 0, 0, 0, 0, 0));
	endtask

	task automatic test_magnet_edges();
		send_sample(make_sample(2, mhed_pkg::KIND_MAGNET, 2048, 2048, 100, 20, 0, 0, 0, 0));
		send_sample(make_sample(2, mhed_pkg::KIND_MAGNET, 4095, 2048, 100, 20, 0, 0, 0, 0));
		send_sample(make_sample(2, mhed_pkg::KIND_MAGNET, 2128, 2048, 100, 20, 0, 0, 0, 0));
		send_sample(make_sample(2, mhed_pkg::KIND_MAGNET, 0, 2048, 100, 20, 0, 0, 0, 0));
		send_sample(make_sample(2, mhed_pkg::KIND_MAGNET, 1968, 2048, 100, 20, 0, 0, 0, 0));
	endtask

	task automatic test_zero_width_window();
		send_sample(make_sample(3, mhed_pkg::KIND_MAGNET, 0, 4095, 0, 255, 0, 0, 0, 0));
		send_sample(make_sample(3, mhed_pkg::KIND_MAGNET, 4095, 4095, 0, 255, 0, 0, 0, 0));
	endtask

	task automatic test_switch_kind();
		send_sample(make_sample(4, mhed_pkg::KIND_SWITCH, 0, 0, 0, 255, 1, 0, 0, 0));
		send_sample(make_sample(4, mhed_pkg::KIND_SWITCH, 95, 0, 0, 255, 1, 0, 0, 0));
		send_sample(make_sample(4, mhed_pkg::KIND_SWITCH, 96, 0, 0, 255, 1, 0, 0, 0));
		send_sample(make_sample(4, mhed_pkg::KIND_SWITCH, 0, 0, 0, 255, 1, 0, 0, 0));
	endtask

	task automatic test_disable_off();
		send_sample(make_sample(5, mhed_pkg::KIND_ANALOGUE, 0, 0, 10, 5, 0, 1, 0, 0));
		send_sample(make_sample(5, mhed_pkg::KIND_ANALOGUE, 240, 0, 10, 5, 0, 1, 0, 0));
		send_sample(make_sample(5, mhed_pkg::KIND_ANALOGUE, 0, 0, 10, 5, 0, 1, 0, 0));
	endtask

	task automatic test_toggle_mode();
		send_sample(make_sample(6, mhed_pkg::KIND_ANALOGUE, 4095, 0, 0, 255, 0, 0, 1, 0));
		send_sample(make_sample(6, mhed_pkg::KIND_ANALOGUE, 0, 0, 0, 255, 0, 0, 1, 0));
		send_sample(make_sample(6, mhed_pkg::KIND_ANALOGUE, 4095, 0, 0, 255, 0, 0, 1, 0));
		send_sample(make_sample(6, mhed_pkg::KIND_ANALOGUE, 0, 0, 0, 255, 0, 0, 1, 1));
		send_sample(make_sample(6, mhed_pkg::KIND_ANALOGUE, 4095, 0, 0, 255, 0, 0, 1, 1));
	endtask

	task automatic test_unreachable_edges();
		send_sample(make_sample(7, mhed_pkg::KIND_MAGNET, 4095, 4095, 255, 0, 0, 0, 0, 0));
		send_sample(make_sample(7, mhed_pkg::KIND_MAGNET, 4095, 4095, 255, 0, 0, 0, 0, 0));
		send_sample(make_sample(7, mhed_pkg::KIND_MAGNET, 255, 0, 255, 255, 0, 0, 0, 0));
		send_sample(make_sample(7, mhed_pkg::KIND_MAGNET, 0, 0, 255, 255, 0, 0, 0, 0));
	endtask

	task automatic test_random_traffic(input int count, input gap_mode_t gaps,
			input stall_mode_t stalls);
		mhed_pkg::item_t it;
		logic [63:0] raw;
		int sent;
		int ch;
		int roll;
		gap_mode = gaps;
		stall_mode = stalls;
		sent = 0;
		while (sent < count) begin
			ch = $urandom_range(NUM_CHANNELS - 1, 0);
			if ($urandom_range(99, 0) < 4)
				chan_settings[ch] = random_settings(ch);
			it = chan_settings[ch];
			roll = $urandom_range(99, 0);
			if (roll < 12) begin
				raw = {$urandom, $urandom};
				it = raw[$bits(mhed_pkg::item_t)-1:0];
				it.channel = ch[3:0];
				it.offset = 12'($urandom);
				it.sample = 12'($urandom);
			end else begin
				it.sample = pick_sample(it);
			end
			send_sample(it);
			if (it.kind != mhed_pkg::KIND_IGNORED)
				sent++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			ch_zone[c] = ZONE_OFF;
			ch_armed[c] = 1'b0;
			ch_toggle[c] = 1'b0;
			chan_settings[c] = random_settings(c);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_kind();
		test_arming();
		test_magnet_edges();
		wait_all_events();
		test_zero_width_window();
		test_switch_kind();
		test_disable_off();
		test_toggle_mode();
		test_unreachable_edges();
		wait_all_events();
		test_random_traffic(300, GAPS_NONE, STALL_NONE);
		wait_all_events();
		test_random_traffic(300, GAPS_SHORT, STALL_HEAVY);
		wait_all_events();
		test_random_traffic(330, GAPS_LONG, STALL_LIGHT);
		wait_all_events();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_events.size() == 0)
			$display("multichannel_hysteresis_event_detector_unit: match");
		else
			$display("multichannel_hysteresis_event_detector_unit: mismatch");
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("multichannel_hysteresis_event_detector_unit: mismatch");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mhed_pkg.sv
rtl/core/mhed_front.sv
rtl/core/mhed_fifo.sv
rtl/core/mhed_back.sv
rtl/core/multichannel_hysteresis_event_detector_unit.sv
test/multichannel_hysteresis_event_detector_unit_tb.sv
